FILE: rtl/stack_vm_load_store_branch_top_defines.svh
// Assertion macros shared by the RTL of the stack VM block.
// Depends on nothing; included by the files that carry assertions.
`ifndef STACK_VM_LOAD_STORE_BRANCH_TOP_DEFINES_SVH
`define STACK_VM_LOAD_STORE_BRANCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("svm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("svm check failed");

`endif

FILE: rtl/svm_pkg.sv
// Package of the stack VM block: sizes, opcode values and memory port types.
// Depends on nothing; used by svm_dmem and the top level.
`timescale 1ns / 1ps

package svm_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int ROWS        = MEM_BYTES / 4;
    localparam int ROW_W       = ADDR_W - 2;
    localparam int SP_W        = ADDR_W + 1;
    localparam int PC_BITS     = 16;

    localparam int OPCODE_W    = 6;
    localparam int WORD_W      = 32;
    localparam int NEXT_PC_W   = 16;
    localparam int STACK_TOP_W = 13;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 64;

    localparam logic [OPCODE_W-1:0] OP_LEA  = 6'd0;
    localparam logic [OPCODE_W-1:0] OP_IMM  = 6'd1;
    localparam logic [OPCODE_W-1:0] OP_JMP  = 6'd2;
    localparam logic [OPCODE_W-1:0] OP_CALL = 6'd3;
    localparam logic [OPCODE_W-1:0] OP_JZ   = 6'd4;
    localparam logic [OPCODE_W-1:0] OP_JNZ  = 6'd5;
    localparam logic [OPCODE_W-1:0] OP_LI   = 6'd9;
    localparam logic [OPCODE_W-1:0] OP_LC   = 6'd10;
    localparam logic [OPCODE_W-1:0] OP_SI   = 6'd11;
    localparam logic [OPCODE_W-1:0] OP_SC   = 6'd12;
    localparam logic [OPCODE_W-1:0] OP_PUSH = 6'd13;

    // Byte-addressed word read: data comes back in the cycle after en.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // Byte-addressed word write: mask bit k enables byte k at addr + k.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        mask;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

endpackage

FILE: rtl/stack_vm_load_store_branch_top.sv
// Stack VM executing one instruction per request. A request passes the issue slot,
// the execute slot and the result register. The issue slot may take a new request
// while the previous instruction sits in execute, but issue is held until execute
// is free, so one instruction at a time makes the single pass over the data memory
// (read at issue, write back when it commits from execute). After reset the memory
// is cleared, MEM_BYTES/4 = 1024 rows, with s_tready low; acc, pc = 0, sp = top.
`timescale 1ns / 1ps

`include "stack_vm_load_store_branch_top_defines.svh"

module stack_vm_load_store_branch_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [5:0] opcode, [37:6] operand_word, [39:38] zero
    input  logic [svm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: [15:0] next_pc, [47:16] acc_value, [60:48] stack_top,
    //          [61] status, [63:62] zero
    output logic [svm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import svm_pkg::*;

    // Architectural state.
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [PC_BITS-1:0]  pc_reg, pc_next;
    logic [SP_W-1:0]     sp_reg, sp_next;

    // Issue slot: holds the accepted request until the memory read goes out.
    logic                iss_valid_reg;
    logic [OPCODE_W-1:0] iss_op_reg;
    logic [WORD_W-1:0]   iss_word_reg;

    // Execute slot: read data is back, results commit here.
    logic                ex_valid_reg;
    logic [OPCODE_W-1:0] ex_op_reg;
    logic [WORD_W-1:0]   ex_word_reg;

    // Result register.
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                status_next;
    logic                iss_fire;
    logic                ex_fire;
    logic                clr_busy;
    logic [WORD_W-1:0]   rdata;
    mem_rd_t             rd;
    mem_wr_t             wr;

    logic [ADDR_W-1:0]   sp_lo;
    logic [ADDR_W-1:0]   push_lo;
    logic [ADDR_W-1:0]   pop_lo;
    logic [PC_BITS-1:0]  pc_plus1;
    logic [PC_BITS-1:0]  pc_plus2;
    logic [PC_BITS-1:0]  target;

    function automatic logic [SP_W-1:0] sp_norm(input logic [ADDR_W-1:0] a);
        sp_norm = (a == '0) ? SP_W'(MEM_BYTES) : {1'b0, a};
    endfunction

    function automatic logic [WORD_W-1:0] sext8(input logic [7:0] b);
        sext8 = {{(WORD_W - 8){b[7]}}, b};
    endfunction

    // Hold issue while execute is occupied: the read must see committed state.
    assign iss_fire = iss_valid_reg && !ex_valid_reg;
    // Commit only when the result register is free or being drained.
    assign ex_fire  = ex_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !clr_busy && (!iss_valid_reg || iss_fire);

    assign sp_lo    = sp_reg[ADDR_W-1:0];
    assign push_lo  = sp_lo - ADDR_W'(4);
    assign pop_lo   = sp_lo + ADDR_W'(4);
    assign pc_plus1 = pc_reg + PC_BITS'(1);
    assign pc_plus2 = pc_reg + PC_BITS'(2);
    assign target   = ex_word_reg[PC_BITS-1:0];

    // Read: loads take the accumulator as address, stores pop at sp.
    always_comb begin
        rd.en   = iss_fire;
        rd.addr = ((iss_op_reg == OP_LI) || (iss_op_reg == OP_LC)) ?
                  acc_reg[ADDR_W-1:0] : sp_lo;
    end

    // Execute: compute next state and the write-back from the read data.
    always_comb begin
        acc_next    = acc_reg;
        pc_next     = pc_plus1;
        sp_next     = sp_reg;
        status_next = 1'b0;
        wr.en       = 1'b0;
        wr.addr     = push_lo;
        wr.mask     = 4'b1111;
        wr.data     = acc_reg;
        unique case (ex_op_reg)
            OP_IMM: begin
                acc_next = ex_word_reg;
                pc_next  = pc_plus2;
            end
            OP_JMP: begin
                pc_next = target;
            end
            OP_CALL: begin
                pc_next = target;
                sp_next = sp_norm(push_lo);
                wr.en   = ex_fire;
                wr.data = WORD_W'(pc_plus2);
            end
            OP_JZ: begin
                pc_next = (acc_reg == '0) ? target : pc_plus2;
            end
            OP_JNZ: begin
                pc_next = (acc_reg != '0) ? target : pc_plus2;
            end
            OP_LI: begin
                acc_next = rdata;
            end
            OP_LC: begin
                acc_next = sext8(rdata[7:0]);
            end
            OP_SI: begin
                sp_next = sp_norm(pop_lo);
                wr.en   = ex_fire;
                wr.addr = rdata[ADDR_W-1:0];
            end
            OP_SC: begin
                sp_next  = sp_norm(pop_lo);
                acc_next = sext8(acc_reg[7:0]);
                wr.en    = ex_fire;
                wr.addr  = rdata[ADDR_W-1:0];
                wr.mask  = 4'b0001;
            end
            OP_PUSH: begin
                sp_next = sp_norm(push_lo);
                wr.en   = ex_fire;
            end
            default: begin
                // LEA and undefined codes: advance pc by one, flag it.
                status_next = 1'b1;
            end
        endcase
    end

    svm_dmem u_dmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd       (rd),
        .wr       (wr),
        .rdata    (rdata),
        .clr_busy (clr_busy)
    );

    // Control and architectural registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_valid_reg <= 1'b0;
            ex_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            acc_reg       <= '0;
            pc_reg        <= '0;
            sp_reg        <= SP_W'(MEM_BYTES);
        end else begin
            if (s_tvalid && s_tready) begin
                iss_valid_reg <= 1'b1;
            end else if (iss_fire) begin
                iss_valid_reg <= 1'b0;
            end
            if (iss_fire) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                m_tvalid_reg <= 1'b1;
                acc_reg      <= acc_next;
                pc_reg       <= pc_next;
                sp_reg       <= sp_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: advance with their slot, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            iss_op_reg   <= s_tdata[OPCODE_W-1:0];
            iss_word_reg <= s_tdata[OPCODE_W +: WORD_W];
        end
        if (iss_fire) begin
            ex_op_reg   <= iss_op_reg;
            ex_word_reg <= iss_word_reg;
        end
        if (ex_fire) begin
            m_tdata_reg <= {2'b00, status_next, STACK_TOP_W'(sp_next),
                            acc_next, NEXT_PC_W'(pc_next)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SVM_ASSERT_NEXT(a_iss_to_ex, aclk, aresetn, iss_fire, ex_valid_reg)
    `SVM_ASSERT_NEXT(a_commit_shows, aclk, aresetn, ex_fire, m_tvalid)
    `SVM_ASSERT_NEXT(a_ex_holds, aclk, aresetn, ex_valid_reg && !ex_fire, ex_valid_reg)
    `SVM_ASSERT_NOW(a_no_exec_in_clear, aclk, aresetn, ex_valid_reg || iss_valid_reg, !clr_busy)
    `SVM_ASSERT_NOW(a_sp_nonzero, aclk, aresetn, 1'b1, sp_reg != '0)

endmodule

FILE: rtl/svm_dmem.sv
// Data/stack memory of the stack VM: four byte banks, wrapping word access.
// Depends on svm_pkg; clears itself one row per cycle after reset.
`timescale 1ns / 1ps

module svm_dmem (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  svm_pkg::mem_rd_t       rd,
    input  svm_pkg::mem_wr_t       wr,
    output logic [31:0]            rdata,
    output logic                   clr_busy
);
    import svm_pkg::*;

    logic [7:0]       mem [4][ROWS];
    logic [7:0]       rd_q [4];
    logic [1:0]       lo_reg;
    logic             clr_busy_reg;
    logic [ROW_W-1:0] clr_row_reg;

    logic [ROW_W-1:0] rrow [4];
    logic [ROW_W-1:0] wrow [4];
    logic [7:0]       wdat [4];
    logic [3:0]       we;

    // Bank b holds byte k = (b - addr) mod 4 of a word at addr.
    always_comb begin
        logic [1:0]        rk;
        logic [1:0]        wk;
        logic [ADDR_W-1:0] rsum;
        logic [ADDR_W-1:0] wsum;
        for (int b = 0; b < 4; b++) begin
            rk      = 2'(b) - rd.addr[1:0];
            rsum    = rd.addr + ADDR_W'(rk);
            rrow[b] = rsum[ADDR_W-1:2];
            wk      = 2'(b) - wr.addr[1:0];
            wsum    = wr.addr + ADDR_W'(wk);
            if (clr_busy_reg) begin
                we[b]   = 1'b1;
                wrow[b] = clr_row_reg;
                wdat[b] = '0;
            end else begin
                we[b]   = wr.en & wr.mask[wk];
                wrow[b] = wsum[ADDR_W-1:2];
                wdat[b] = wr.data[8*wk +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (we[b]) begin
                mem[b][wrow[b]] <= wdat[b];
            end
            if (rd.en) begin
                rd_q[b] <= mem[b][rrow[b]];
            end
        end
        if (rd.en) begin
            lo_reg <= rd.addr[1:0];
        end
    end

    // Clearing pass: one row of four bytes per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rdata[8*k +: 8] = rd_q[lo_reg + 2'(k)];
        end
    end

    assign clr_busy = clr_busy_reg;

endmodule
